@@ sv/cpp_pkg.sv @@
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int LANE_W    = 16;                       // config lane, Q8.8
    localparam int COORD_W   = 16;                       // point field, Q8.8
    localparam int CFG_W     = 3 * LANE_W;               // packed x,y,z register
    localparam int CFG_IDX_W = 8;
    localparam int OFS_W     = ((COORD_W > LANE_W) ? COORD_W : LANE_W) + 1;
    localparam int CROSS_W   = 2 * LANE_W + 1;           // cross product component
    localparam int DET_W     = OFS_W + CROSS_W + 2;      // triple product
    localparam int MAG_W     = DET_W;                    // determinant magnitude
    localparam int Q_W       = 16;                       // quotient bits
    localparam int FRAC_SH   = 11;                       // *2048
    localparam int SAT_SH    = Q_W - FRAC_SH;            // quotient >= 32 saturates
    localparam int REM_W     = MAG_W + Q_W;
    localparam int OUT_W     = 16;
    localparam int SUM_W     = OUT_W + 2;
    localparam int HALF_Q412 = 2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_CENTER  = 8'd0,
        REG_VIEW_DIRECTION = 8'd1,
        REG_VIEW_AXIS_ONE  = 8'd2,
        REG_VIEW_AXIS_TWO  = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_x;
    } point_t;

    typedef struct packed {
        logic                    degenerate;
        logic                    visible;
        logic signed [OUT_W-1:0] screen_v;
        logic signed [OUT_W-1:0] screen_u;
    } result_t;

    // One divider stage: both ratios share the denominator.
    typedef struct packed {
        logic [REM_W-1:0] rem_b;
        logic [REM_W-1:0] rem_c;
        logic [Q_W-1:0]   q_b;
        logic [Q_W-1:0]   q_c;
        logic [MAG_W-1:0] den;
        logic             sat_b;
        logic             sat_c;
        logic             neg_b;
        logic             neg_c;
        logic             vis;
        logic             degen;
    } div_stage_t;

endpackage

@@ sv/camera_point_projection_top.sv @@
`timescale 1ns / 1ps

// Pipeline from point transaction to result: 3 determinant stages,
//   1 sign/magnitude stage, 16 restoring-divider stages, 1 output stage.
// Throughput: one point per cycle; a full stage holds only while the stage after it holds.
// Reset (rst_n low, async): all valid bits and all four camera registers clear to zero.
module camera_point_projection_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpp_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              point_valid,
    output logic                              point_stall,
    input  cpp_pkg::point_t                   point,
    output logic                              result_valid,
    input  logic                              result_stall,
    output cpp_pkg::result_t                  result
);
    import cpp_pkg::*;

    localparam int DIV_STG = Q_W;
    localparam int NSTG    = 4 + DIV_STG + 1;
    localparam int S_DIV0  = 4;
    localparam int S_OUT   = NSTG - 1;

    // ---------------- camera registers ----------------
    logic [CFG_W-1:0] center_reg, dir_reg, axis1_reg, axis2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            dir_reg    <= '0;
            axis1_reg  <= '0;
            axis2_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CAMERA_CENTER:  center_reg <= cfg_data;
                REG_VIEW_DIRECTION: dir_reg    <= cfg_data;
                REG_VIEW_AXIS_ONE:  axis1_reg  <= cfg_data;
                REG_VIEW_AXIS_TWO:  axis2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [LANE_W-1:0] cc [3];
    logic signed [LANE_W-1:0] dd [3];
    logic signed [LANE_W-1:0] vv [3];
    logic signed [LANE_W-1:0] uu [3];
    logic signed [COORD_W-1:0] pp [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cc[i] = signed'(center_reg[LANE_W*i +: LANE_W]);
            dd[i] = signed'(dir_reg[LANE_W*i +: LANE_W]);
            vv[i] = signed'(axis1_reg[LANE_W*i +: LANE_W]);
            uu[i] = signed'(axis2_reg[LANE_W*i +: LANE_W]);
        end
        pp[0] = point.point_x;
        pp[1] = point.point_y;
        pp[2] = point.point_z;
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or its successor loads. Bubbles collapse.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   en;

    always_comb
    begin
        en[NSTG] = !result_stall;
        for (int i = NSTG - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign point_stall  = !en[0];
    assign result_valid = vld_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= point_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- stage 1: offset and cross products ----------------
    // det = d.(v x u), aDet = o.(v x u), bDet = o.(u x d), cDet = o.(d x v)
    logic signed [OFS_W-1:0]   ofs_reg [3];
    logic signed [CROSS_W-1:0] xvu_reg [3];
    logic signed [CROSS_W-1:0] xud_reg [3];
    logic signed [CROSS_W-1:0] xdv_reg [3];

    function automatic logic signed [CROSS_W-1:0] cross_comp(
        input logic signed [LANE_W-1:0] a1, input logic signed [LANE_W-1:0] b2,
        input logic signed [LANE_W-1:0] a2, input logic signed [LANE_W-1:0] b1);
        logic signed [CROSS_W-1:0] p, q;
        p = CROSS_W'(a1) * CROSS_W'(b2);
        q = CROSS_W'(a2) * CROSS_W'(b1);
        return p - q;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ofs_reg[i] <= OFS_W'(pp[i]) - OFS_W'(cc[i]);
                xvu_reg[i] <= cross_comp(vv[(i+1)%3], uu[(i+2)%3],
                                         vv[(i+2)%3], uu[(i+1)%3]);
                xud_reg[i] <= cross_comp(uu[(i+1)%3], dd[(i+2)%3],
                                         uu[(i+2)%3], dd[(i+1)%3]);
                xdv_reg[i] <= cross_comp(dd[(i+1)%3], vv[(i+2)%3],
                                         dd[(i+2)%3], vv[(i+1)%3]);
            end
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [DET_W-1:0] pd_reg [3];
    logic signed [DET_W-1:0] pa_reg [3];
    logic signed [DET_W-1:0] pb_reg [3];
    logic signed [DET_W-1:0] pc_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= DET_W'(dd[i]) * DET_W'(xvu_reg[i]);
                pa_reg[i] <= DET_W'(ofs_reg[i]) * DET_W'(xvu_reg[i]);
                pb_reg[i] <= DET_W'(ofs_reg[i]) * DET_W'(xud_reg[i]);
                pc_reg[i] <= DET_W'(ofs_reg[i]) * DET_W'(xdv_reg[i]);
            end
        end
    end

    // ---------------- stage 3: determinants ----------------
    logic signed [DET_W-1:0] det_reg, adet_reg, bdet_reg, cdet_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            det_reg  <= pd_reg[0] + pd_reg[1] + pd_reg[2];
            adet_reg <= pa_reg[0] + pa_reg[1] + pa_reg[2];
            bdet_reg <= pb_reg[0] + pb_reg[1] + pb_reg[2];
            cdet_reg <= pc_reg[0] + pc_reg[1] + pc_reg[2];
        end
    end

    // ---------------- stage 4: flags and magnitudes ----------------
    logic             vis_reg, degen_reg, negb_reg, negc_reg;
    logic [MAG_W-1:0] ub_reg, uc_reg, ud_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            degen_reg <= (det_reg == '0);
            vis_reg   <= (det_reg != '0) && (adet_reg != '0)
                         && (adet_reg[DET_W-1] == det_reg[DET_W-1]);
            negb_reg  <= bdet_reg[DET_W-1] ^ adet_reg[DET_W-1];
            negc_reg  <= cdet_reg[DET_W-1] ^ adet_reg[DET_W-1];
            ub_reg    <= MAG_W'(bdet_reg[DET_W-1] ? -bdet_reg : bdet_reg);
            uc_reg    <= MAG_W'(cdet_reg[DET_W-1] ? -cdet_reg : cdet_reg);
            ud_reg    <= MAG_W'(adet_reg[DET_W-1] ? -adet_reg : adet_reg);
        end
    end

    // ---------------- stages 5..20: restoring divider, one bit each ----------------
    // Computes floor(num*2048/den) MSB first; num >= 32*den saturates.
    div_stage_t div_reg  [DIV_STG];
    div_stage_t div_next [DIV_STG];
    div_stage_t div_in   [DIV_STG];

    always_comb
    begin
        div_in[0].rem_b = REM_W'(ub_reg) << FRAC_SH;
        div_in[0].rem_c = REM_W'(uc_reg) << FRAC_SH;
        div_in[0].q_b   = '0;
        div_in[0].q_c   = '0;
        div_in[0].den   = ud_reg;
        div_in[0].sat_b = REM_W'(ub_reg) >= (REM_W'(ud_reg) << SAT_SH);
        div_in[0].sat_c = REM_W'(uc_reg) >= (REM_W'(ud_reg) << SAT_SH);
        div_in[0].neg_b = negb_reg;
        div_in[0].neg_c = negc_reg;
        div_in[0].vis   = vis_reg;
        div_in[0].degen = degen_reg;
        for (int j = 1; j < DIV_STG; j++)
        begin
            div_in[j] = div_reg[j-1];
        end
    end

    always_comb
    begin
        div_stage_t   cur;
        logic [REM_W-1:0] dsh;
        for (int j = 0; j < DIV_STG; j++)
        begin
            cur = div_in[j];
            dsh = REM_W'(cur.den) << (Q_W - 1 - j);
            if (cur.rem_b >= dsh)
            begin
                cur.rem_b = cur.rem_b - dsh;
                cur.q_b[Q_W-1-j] = 1'b1;
            end
            if (cur.rem_c >= dsh)
            begin
                cur.rem_c = cur.rem_c - dsh;
                cur.q_c[Q_W-1-j] = 1'b1;
            end
            div_next[j] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STG; j++)
        begin
            if (en[S_DIV0 + j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // ---------------- stage 21: sign, offset, saturation ----------------
    function automatic logic signed [OUT_W-1:0] finish(
        input logic [Q_W-1:0] q, input logic sat, input logic neg);
        logic signed [SUM_W-1:0] mag, val;
        mag = sat ? SUM_W'(1 << Q_W) : SUM_W'(q);
        val = (neg ? -mag : mag) + SUM_W'(HALF_Q412);
        if (val < -(SUM_W'(1) <<< (OUT_W - 1)))
        begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end
        else if (val > (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1))
        begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
        return OUT_W'(val);
    endfunction

    result_t    res_reg;
    div_stage_t last;

    assign last = div_reg[DIV_STG-1];

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            res_reg.visible    <= last.vis;
            res_reg.degenerate <= last.degen;
            res_reg.screen_u   <= last.vis ? finish(last.q_b, last.sat_b, last.neg_b) : '0;
            res_reg.screen_v   <= last.vis ? finish(last.q_c, last.sat_c, last.neg_c) : '0;
        end
    end

    assign result = res_reg;

    // ---------------- checks ----------------
    a_vis_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.visible |-> !result.degenerate)
        else $error("visible result with zero basis determinant");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.visible |-> result.screen_u == '0 && result.screen_v == '0)
        else $error("invisible result with nonzero coordinates");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> !point_stall)
        else $error("input stalled with empty first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_OUT] && !result_stall && !vld_reg[S_OUT-1] |=> !result_valid)
        else $error("result repeated after transaction");

endmodule
